@@ sv/tlv_reply_message_parser_defines.svh @@
// Assertion macros for the reply parser.
`ifndef TLV_REPLY_MESSAGE_PARSER_DEFINES_SVH
`define TLV_REPLY_MESSAGE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define TLVP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define TLVP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLVP_ASSERT_IMP(lbl, ante, cons, msg)
`define TLVP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/tlvp_pkg.sv @@
package tlvp_pkg;

    localparam int MESSAGE_BYTES_MAX = 65536;
    localparam int KEY_SPACE         = 256;

    localparam int KEY_W    = 8;
    localparam int REG_IDX_W = 8;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [REG_IDX_W-1:0] CFG_PROTOCOL_VERSION    = 8'd0;
    localparam logic [REG_IDX_W-1:0] CFG_FIELD_COUNT_LIMIT   = 8'd1;
    localparam logic [REG_IDX_W-1:0] CFG_FIELD_BYTES_LIMIT   = 8'd2;
    localparam logic [REG_IDX_W-1:0] CFG_MESSAGE_BYTES_LIMIT = 8'd3;

    // register reset values
    localparam logic [7:0]  PROTOCOL_VERSION_RST    = 8'd1;
    localparam logic [7:0]  FIELD_COUNT_LIMIT_RST   = 8'd16;
    localparam logic [15:0] FIELD_BYTES_LIMIT_RST   = 16'd4096;
    localparam logic [16:0] MESSAGE_BYTES_LIMIT_RST = 17'd65536;

    // "MWLR"
    localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h57, 8'h4C, 8'h52};

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_KEY    = 3'd1,
        PH_LENGTH = 3'd2,
        PH_VALUE  = 3'd3,
        PH_END    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_KEY     = 3'd1,
        ROLE_LENGTH  = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_DISCARD = 3'd4
    } role_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SHORT      = 4'd1,
        ERR_LONG       = 4'd2,
        ERR_MAGIC      = 4'd3,
        ERR_VERSION    = 4'd4,
        ERR_STATUS     = 4'd5,
        ERR_COUNT      = 4'd6,
        ERR_RESERVED   = 4'd7,
        ERR_TRUNCATED  = 4'd8,
        ERR_FIELD_LONG = 4'd9,
        ERR_OVERRUN    = 4'd10,
        ERR_DUPLICATE  = 4'd11,
        ERR_TRAILING   = 4'd12
    } err_t;

    typedef struct packed {
        logic [7:0]  protocol_version;
        logic [7:0]  field_count_limit;
        logic [15:0] field_bytes_limit;
        logic [16:0] message_bytes_limit;
    } cfg_t;

    typedef struct packed {
        logic             set;
        logic             clear;
        logic [KEY_W-1:0] key;
    } map_req_t;

    typedef struct packed {
        role_t      role;
        logic [7:0] key;
        logic [7:0] data;
        logic       vend;
        logic       done;
        logic       ok;
        logic       peer;
        err_t       code;
    } result_t;

endpackage

@@ sv/tlvp_key_map.sv @@
// Seen-key bitmap: one flop per key, read at one key, cleared whole by one clear request.
module tlvp_key_map #(
    parameter int KEY_SPACE = tlvp_pkg::KEY_SPACE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tlvp_pkg::map_req_t          req,
    input  logic [tlvp_pkg::KEY_W-1:0]  rd_key,
    output logic                        seen
);

    localparam int KW = $clog2(KEY_SPACE);

    logic [KEY_SPACE-1:0] seen_reg;
    logic [KEY_SPACE-1:0] seen_next;

    always_comb begin
        seen_next = seen_reg;
        if (req.clear) begin
            seen_next = '0;
        end else if (req.set) begin
            seen_next[req.key[KW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    assign seen = seen_reg[rd_key[KW-1:0]];

endmodule

@@ sv/tlvp_parse.sv @@
// Per-message parse state and the checks for one word.
module tlvp_parse #(
    parameter int MESSAGE_BYTES_MAX = tlvp_pkg::MESSAGE_BYTES_MAX
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [7:0]                  data_byte,
    input  logic                        final_byte,
    input  tlvp_pkg::cfg_t              cfg,
    input  logic                        key_seen,
    output tlvp_pkg::map_req_t          map_req,
    output logic [tlvp_pkg::KEY_W-1:0]  map_key,
    output tlvp_pkg::result_t           result
);

    localparam int PW = $clog2(MESSAGE_BYTES_MAX + 1);
    localparam int CW = (PW > 17) ? PW : 17;
    localparam int EW = 33;

    tlvp_pkg::phase_t phase_reg, phase_next;
    tlvp_pkg::err_t   first_error_reg, first_error_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       fields_expected_reg, fields_expected_next;
    logic [7:0]       fields_seen_reg, fields_seen_next;
    logic [7:0]       current_key_reg, current_key_next;
    logic [23:0]      len_acc_reg, len_acc_next;
    logic [1:0]       len_idx_reg, len_idx_next;
    logic [15:0]      value_rem_reg, value_rem_next;
    logic             status_reg, status_next;

    logic [PW-1:0]    limit;
    logic [CW-1:0]    limit_cfg;
    logic             in_limit;
    logic [31:0]      len_full;
    logic [EW-1:0]    field_end;
    logic [7:0]       fields_inc;
    logic [15:0]      rem_dec;
    logic             status_upd;
    tlvp_pkg::err_t   raise;
    tlvp_pkg::err_t   err_after;
    tlvp_pkg::err_t   verdict;

    // limit in force is the smaller of the register and the build maximum
    assign limit_cfg = CW'(cfg.message_bytes_limit);
    assign limit     = (limit_cfg > CW'(MESSAGE_BYTES_MAX)) ? PW'(MESSAGE_BYTES_MAX)
                                                           : PW'(limit_cfg);
    assign in_limit  = (pos_reg < limit);

    assign len_full   = {data_byte, len_acc_reg};
    assign field_end  = EW'(pos_reg) + EW'(1) + EW'(len_full);
    assign fields_inc = fields_seen_reg + 8'd1;
    assign rem_dec    = (value_rem_reg != 16'd0) ? (value_rem_reg - 16'd1) : 16'd0;
    assign map_key    = current_key_reg;

    // next state
    always_comb begin
        phase_next           = phase_reg;
        pos_next             = (pos_reg != '1) ? (pos_reg + PW'(1)) : pos_reg;
        fields_expected_next = fields_expected_reg;
        fields_seen_next     = fields_seen_reg;
        current_key_next     = current_key_reg;
        len_acc_next         = len_acc_reg;
        len_idx_next         = len_idx_reg;
        value_rem_next       = value_rem_reg;
        status_upd           = status_reg;
        raise                = tlvp_pkg::ERR_NONE;
        map_req              = '0;
        map_req.key          = current_key_reg;

        if (first_error_reg != tlvp_pkg::ERR_NONE) begin
            // discarding until the final word
        end else if (!in_limit) begin
            raise = tlvp_pkg::ERR_LONG;
        end else begin
            unique case (phase_reg)
                tlvp_pkg::PH_HEADER: begin
                    if (!pos_reg[2]) begin
                        if (data_byte != tlvp_pkg::MAGIC[pos_reg[1:0]]) begin
                            raise = tlvp_pkg::ERR_MAGIC;
                        end
                    end else begin
                        case (pos_reg[1:0])
                            2'd0: begin
                                if (data_byte != cfg.protocol_version) begin
                                    raise = tlvp_pkg::ERR_VERSION;
                                end
                            end
                            2'd1: begin
                                if (data_byte > 8'd1) begin
                                    raise = tlvp_pkg::ERR_STATUS;
                                end
                                status_upd = (data_byte == 8'd0);
                            end
                            2'd2: begin
                                if (data_byte > cfg.field_count_limit) begin
                                    raise = tlvp_pkg::ERR_COUNT;
                                end
                                fields_expected_next = data_byte;
                            end
                            default: begin
                                if (data_byte != 8'd0) begin
                                    raise = tlvp_pkg::ERR_RESERVED;
                                end
                                fields_seen_next = 8'd0;
                                phase_next = (fields_expected_reg == 8'd0) ? tlvp_pkg::PH_END
                                                                           : tlvp_pkg::PH_KEY;
                            end
                        endcase
                    end
                end
                tlvp_pkg::PH_KEY: begin
                    current_key_next = data_byte;
                    len_acc_next     = '0;
                    len_idx_next     = 2'd0;
                    phase_next       = tlvp_pkg::PH_LENGTH;
                end
                tlvp_pkg::PH_LENGTH: begin
                    case (len_idx_reg)
                        2'd0: len_acc_next[7:0]   = data_byte;
                        2'd1: len_acc_next[15:8]  = data_byte;
                        2'd2: len_acc_next[23:16] = data_byte;
                        default: begin
                            len_idx_next = 2'd0;
                            if (len_full > 32'(cfg.field_bytes_limit)) begin
                                raise = tlvp_pkg::ERR_FIELD_LONG;
                            end else if (field_end > EW'(limit)) begin
                                raise = tlvp_pkg::ERR_OVERRUN;
                            end else if (key_seen) begin
                                raise = tlvp_pkg::ERR_DUPLICATE;
                            end else begin
                                map_req.set      = 1'b1;
                                fields_seen_next = fields_inc;
                                value_rem_next   = len_full[15:0];
                                if (len_full[15:0] == 16'd0) begin
                                    phase_next = (fields_inc >= fields_expected_reg)
                                               ? tlvp_pkg::PH_END : tlvp_pkg::PH_KEY;
                                end else begin
                                    phase_next = tlvp_pkg::PH_VALUE;
                                end
                            end
                        end
                    endcase
                    if (len_idx_reg != 2'd3) begin
                        len_idx_next = len_idx_reg + 2'd1;
                    end
                end
                tlvp_pkg::PH_VALUE: begin
                    value_rem_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        phase_next = (fields_seen_reg >= fields_expected_reg)
                                   ? tlvp_pkg::PH_END : tlvp_pkg::PH_KEY;
                    end
                end
                default: begin
                    raise = tlvp_pkg::ERR_TRAILING;
                end
            endcase
        end

        err_after = (first_error_reg != tlvp_pkg::ERR_NONE) ? first_error_reg : raise;
        first_error_next = err_after;
        status_next      = status_upd;

        // verdict: message ending outside the end phase is short or truncated
        verdict = err_after;
        if (err_after == tlvp_pkg::ERR_NONE && phase_next != tlvp_pkg::PH_END) begin
            verdict = (phase_next == tlvp_pkg::PH_HEADER) ? tlvp_pkg::ERR_SHORT
                                                          : tlvp_pkg::ERR_TRUNCATED;
        end

        if (final_byte) begin
            phase_next           = tlvp_pkg::PH_HEADER;
            pos_next             = '0;
            fields_expected_next = '0;
            fields_seen_next     = '0;
            current_key_next     = '0;
            len_acc_next         = '0;
            len_idx_next         = '0;
            value_rem_next       = '0;
            first_error_next     = tlvp_pkg::ERR_NONE;
            status_next          = 1'b0;
            map_req.clear        = 1'b1;
        end

        if (!step) begin
            map_req.set   = 1'b0;
            map_req.clear = 1'b0;
        end
    end

    // result for this word
    always_comb begin
        result      = '0;
        result.role = tlvp_pkg::ROLE_DISCARD;
        result.data = data_byte;
        result.done = final_byte;
        if (first_error_reg == tlvp_pkg::ERR_NONE && in_limit) begin
            unique case (phase_reg)
                tlvp_pkg::PH_HEADER: begin
                    result.role = tlvp_pkg::ROLE_HEADER;
                end
                tlvp_pkg::PH_KEY: begin
                    result.role = tlvp_pkg::ROLE_KEY;
                    result.key  = data_byte;
                end
                tlvp_pkg::PH_LENGTH: begin
                    result.role = tlvp_pkg::ROLE_LENGTH;
                    result.key  = current_key_reg;
                end
                tlvp_pkg::PH_VALUE: begin
                    result.role = tlvp_pkg::ROLE_VALUE;
                    result.key  = current_key_reg;
                    result.vend = (rem_dec == 16'd0);
                end
                default: begin
                    result.role = tlvp_pkg::ROLE_DISCARD;
                end
            endcase
        end
        if (final_byte) begin
            result.code = verdict;
            result.ok   = (verdict == tlvp_pkg::ERR_NONE);
            result.peer = (verdict == tlvp_pkg::ERR_NONE) && status_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= tlvp_pkg::PH_HEADER;
            first_error_reg     <= tlvp_pkg::ERR_NONE;
            pos_reg             <= '0;
            fields_expected_reg <= '0;
            fields_seen_reg     <= '0;
            current_key_reg     <= '0;
            len_acc_reg         <= '0;
            len_idx_reg         <= '0;
            value_rem_reg       <= '0;
            status_reg          <= 1'b0;
        end else if (step) begin
            phase_reg           <= phase_next;
            first_error_reg     <= first_error_next;
            pos_reg             <= pos_next;
            fields_expected_reg <= fields_expected_next;
            fields_seen_reg     <= fields_seen_next;
            current_key_reg     <= current_key_next;
            len_acc_reg         <= len_acc_next;
            len_idx_reg         <= len_idx_next;
            value_rem_reg       <= value_rem_next;
            status_reg          <= status_next;
        end
    end

endmodule

@@ sv/tlv_reply_message_parser.sv @@
// Reply message parser.
// Input stream (s_*): one message byte per word, s_tlast on the final byte of
// a message. Every accepted word yields exactly one result word on m_*: the
// byte echoed with its role and field key, value_end on the last value byte
// of a field, and on the final byte (m_tlast) the verdict: message_ok,
// peer_success and the first error code seen in the message.
// Output: a result is registered and is on m_* in the cycle after its word is accepted.
// Throughput: one word per cycle while the result drains. The parse state,
// the seen-key bitmap and the header/field checks all settle combinationally
// between the accepted input and the result register.
// Stall: the result register holds while m_tready is low; s_tready follows
// !m_tvalid || m_tready, so input flows whenever the result drains.
// Config (cfg_*): registers 0 protocol version, 1 field count limit, 2 field
// byte limit, 3 message byte limit; the user must write them only while the
// parser is idle, which the block itself does not enforce. cfg_ready is always high.
// Reset (aresetn low, synchronous): registers to defaults (1, 16, 4096, 65536),
// parse state to the start of a message, seen map cleared, no result pending.
`include "tlv_reply_message_parser_defines.svh"

module tlv_reply_message_parser #(
    parameter int MESSAGE_BYTES_MAX = tlvp_pkg::MESSAGE_BYTES_MAX,
    parameter int KEY_SPACE         = tlvp_pkg::KEY_SPACE
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // final_byte
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] field_key, [15:8] value_byte, [16] value_end, [17] message_ok,
    // [18] peer_success, [22:19] error_code, [23] zero
    output logic [23:0]                       m_tdata,
    output logic [2:0]                        m_tuser,   // [2:0] byte_role
    output logic                              m_tlast,   // message_done
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlvp_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [tlvp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tlvp_pkg::cfg_t              cfg_reg;
    tlvp_pkg::map_req_t          map_req;
    logic [tlvp_pkg::KEY_W-1:0]  map_key;
    logic                        key_seen;
    tlvp_pkg::result_t           result;
    tlvp_pkg::result_t           result_reg;
    logic                        m_tvalid_reg;
    logic                        step;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step      = s_tvalid && s_tready;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_version    <= tlvp_pkg::PROTOCOL_VERSION_RST;
            cfg_reg.field_count_limit   <= tlvp_pkg::FIELD_COUNT_LIMIT_RST;
            cfg_reg.field_bytes_limit   <= tlvp_pkg::FIELD_BYTES_LIMIT_RST;
            cfg_reg.message_bytes_limit <= tlvp_pkg::MESSAGE_BYTES_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tlvp_pkg::CFG_PROTOCOL_VERSION:    cfg_reg.protocol_version <= cfg_data[7:0];
                tlvp_pkg::CFG_FIELD_COUNT_LIMIT:   cfg_reg.field_count_limit <= cfg_data[7:0];
                tlvp_pkg::CFG_FIELD_BYTES_LIMIT:   cfg_reg.field_bytes_limit <= cfg_data[15:0];
                tlvp_pkg::CFG_MESSAGE_BYTES_LIMIT: cfg_reg.message_bytes_limit <= cfg_data;
                default: ; // unmapped index: ignored
            endcase
        end
    end

    tlvp_key_map #(
        .KEY_SPACE (KEY_SPACE)
    ) u_key_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req),
        .rd_key  (map_key),
        .seen    (key_seen)
    );

    tlvp_parse #(
        .MESSAGE_BYTES_MAX (MESSAGE_BYTES_MAX)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .cfg        (cfg_reg),
        .key_seen   (key_seen),
        .map_req    (map_req),
        .map_key    (map_key),
        .result     (result)
    );

    // result register: loads on every accepted word, holds under back-pressure
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg.code, result_reg.peer, result_reg.ok,
                       result_reg.vend, result_reg.data, result_reg.key};
    assign m_tuser  = result_reg.role;
    assign m_tlast  = result_reg.done;

    `TLVP_ASSERT_NXT(a_word_gives_result, step, m_tvalid_reg, "accepted word gave no result")
    `TLVP_ASSERT_IMP(a_ok_is_clean, m_tvalid_reg && result_reg.ok, result_reg.done && (result_reg.code == tlvp_pkg::ERR_NONE), "ok without a clean verdict")
    `TLVP_ASSERT_IMP(a_peer_needs_ok, m_tvalid_reg && result_reg.peer, result_reg.ok, "peer success without ok")
    `TLVP_ASSERT_IMP(a_vend_on_value, m_tvalid_reg && result_reg.vend, result_reg.role == tlvp_pkg::ROLE_VALUE, "value end on a non-value byte")

endmodule
